// ----- sv/eqvr_pkg.sv -----
// shared constants, types and helper functions for the euler quaternion rotator
// no dependencies
package eqvr_pkg;

  localparam int VW = 32;
  localparam int AW = 16;
  localparam int TW = 34;
  localparam int ZW = 34;
  localparam int PW = 2 * TW;
  localparam int MVW = TW + VW;
  localparam int RW = PW + 2;
  localparam int HW = 18;

  localparam int FRAC_BITS = 16;
  localparam int TRIG_ITERATIONS = 16;
  localparam int TRIG_TABLE_LEN = 24;

  localparam logic signed [HW-1:0] HALF_TURN = 18'sd23040;
  localparam logic signed [HW-1:0] QUARTER_TURN = 18'sd11520;
  localparam logic signed [HW-1:0] FULL_TURN = 18'sd46080;
  localparam logic signed [TW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec_t;

  // atan(2^-i) in 2^-24 degree units
  function automatic logic signed [ZW-1:0] atan_deg24(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:  r = 34'sd754974720;
      5'd1:  r = 34'sd445687602;
      5'd2:  r = 34'sd235489089;
      5'd3:  r = 34'sd119537938;
      5'd4:  r = 34'sd60000934;
      5'd5:  r = 34'sd30029717;
      5'd6:  r = 34'sd15018523;
      5'd7:  r = 34'sd7509720;
      5'd8:  r = 34'sd3754917;
      5'd9:  r = 34'sd1877466;
      5'd10: r = 34'sd938734;
      5'd11: r = 34'sd469367;
      5'd12: r = 34'sd234684;
      5'd13: r = 34'sd117342;
      5'd14: r = 34'sd58671;
      5'd15: r = 34'sd29335;
      5'd16: r = 34'sd14668;
      5'd17: r = 34'sd7334;
      5'd18: r = 34'sd3667;
      5'd19: r = 34'sd1833;
      5'd20: r = 34'sd917;
      5'd21: r = 34'sd458;
      5'd22: r = 34'sd229;
      5'd23: r = 34'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round to nearest, drop 30 fraction bits
  function automatic logic signed [TW-1:0] rnd30(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] s;
    s = (v + (RW'(1) <<< 29)) >>> 30;
    return s[TW-1:0];
  endfunction

  // round to nearest, drop 31 fraction bits
  function automatic logic signed [TW-1:0] rnd31(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] s;
    s = (v + (RW'(1) <<< 30)) >>> 31;
    return s[TW-1:0];
  endfunction

endpackage

// ----- sv/eqvr_in_if.sv -----
// input and output channel interfaces of the rotator
// depends on eqvr_pkg
interface eqvr_in_if;
  logic valid;
  logic ready;
  logic signed [eqvr_pkg::VW-1:0] vec_x;
  logic signed [eqvr_pkg::VW-1:0] vec_y;
  logic signed [eqvr_pkg::VW-1:0] vec_z;
  logic signed [eqvr_pkg::AW-1:0] angle_x;
  logic signed [eqvr_pkg::AW-1:0] angle_y;
  logic signed [eqvr_pkg::AW-1:0] angle_z;

  modport source (output valid, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                output ready);
endinterface

interface eqvr_out_if;
  logic valid;
  logic ready;
  logic signed [eqvr_pkg::VW-1:0] out_x;
  logic signed [eqvr_pkg::VW-1:0] out_y;
  logic signed [eqvr_pkg::VW-1:0] out_z;
  logic saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// ----- sv/eqvr_cordic.sv -----
// pipelined rotation-mode cordic: sine and cosine of a half angle
// depends on eqvr_pkg; registered seed, micro-rotation and fold-undo stages
module eqvr_cordic #(
  parameter int ITERATIONS = eqvr_pkg::TRIG_ITERATIONS
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [eqvr_pkg::AW-1:0] angle,
  output logic signed [eqvr_pkg::TW-1:0] sin_val,
  output logic signed [eqvr_pkg::TW-1:0] cos_val
);

  localparam int TW = eqvr_pkg::TW;
  localparam int ZW = eqvr_pkg::ZW;
  localparam int HW = eqvr_pkg::HW;

  logic signed [TW-1:0] x [0:ITERATIONS];
  logic signed [TW-1:0] y [0:ITERATIONS];
  logic signed [ZW-1:0] z [0:ITERATIONS];
  logic                 flip [0:ITERATIONS];

  logic signed [HW-1:0] h0, h1, h2;
  logic                 flip0;

  // wrap into one turn, then fold into the right half plane
  always_comb begin
    h0 = HW'(angle);
    if (h0 > eqvr_pkg::HALF_TURN) begin
      h1 = h0 - eqvr_pkg::FULL_TURN;
    end else if (h0 < -eqvr_pkg::HALF_TURN) begin
      h1 = h0 + eqvr_pkg::FULL_TURN;
    end else begin
      h1 = h0;
    end
    flip0 = 1'b1;
    if (h1 > eqvr_pkg::QUARTER_TURN) begin
      h2 = h1 - eqvr_pkg::HALF_TURN;
    end else if (h1 < -eqvr_pkg::QUARTER_TURN) begin
      h2 = h1 + eqvr_pkg::HALF_TURN;
    end else begin
      h2 = h1;
      flip0 = 1'b0;
    end
  end

  // seed stage
  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= eqvr_pkg::CORDIC_GAIN_Q30;
      y[0]    <= '0;
      z[0]    <= ZW'(h2) <<< 17;
      flip[0] <= flip0;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - eqvr_pkg::atan_deg24(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + eqvr_pkg::atan_deg24(5'(i));
        end
        flip[i+1] <= flip[i];
      end
    end
  end

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= flip[ITERATIONS] ? -y[ITERATIONS] : y[ITERATIONS];
      cos_val <= flip[ITERATIONS] ? -x[ITERATIONS] : x[ITERATIONS];
    end
  end

endmodule

// ----- sv/euler_quaternion_vector_rotate.sv -----
// Euler zxy vector rotator: q = qy*qx*qz, result = q*v*conj(q), saturated.
// Throughput one word per cycle while the output word is not held, set by one cordic
// stage per iteration and one multiply stage per step.
// The pipeline stalls as a whole only while the output word waits.
// Synchronous reset clears the valid bits; the datapath registers are not reset.
module euler_quaternion_vector_rotate #(
  parameter int TRIG_ITERATIONS = eqvr_pkg::TRIG_ITERATIONS
) (
  input logic clk,
  input logic rst,
  eqvr_in_if.sink    vec_in,
  eqvr_out_if.source vec_out
);

  localparam int TW  = eqvr_pkg::TW;
  localparam int PW  = eqvr_pkg::PW;
  localparam int RW  = eqvr_pkg::RW;
  localparam int VW  = eqvr_pkg::VW;
  localparam int MVW = eqvr_pkg::MVW;
  localparam int LC  = TRIG_ITERATIONS + 2;
  localparam int VD  = LC + 6;
  localparam int LAT = LC + 8;

  logic           en;
  logic [LAT-1:0] vld;
  eqvr_pkg::vec_t vecd [0:VD-1];

  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [PW-1:0] p_cysx, p_sycx, p_sysx, p_cycx;
  logic signed [TW-1:0] sz1, cz1, sz2, cz2;
  logic signed [TW-1:0] t0, t1, t2, t3;
  logic signed [PW-1:0] pa0, pa1, pb0, pb1, pc0, pc1, pd0, pd1;
  logic signed [TW-1:0] qx, qy, qz, qw;
  logic signed [PW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [TW-1:0] m [0:8];
  logic signed [MVW-1:0] mv [0:8];
  logic signed [VW-1:0] res [0:2];
  logic [2:0]           sat_row;
  logic signed [RW-1:0] acc [0:2];
  logic signed [VW-1:0] clip [0:2];
  logic signed [VW-1:0] vv [0:2];

  // whole pipe advances unless the output word is held
  assign en = !vld[LAT-1] || vec_out.ready;
  assign vec_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], vec_in.valid};
    end
  end

  // vector delay line alongside the trig and quaternion stages
  always_ff @(posedge clk) begin
    if (en) begin
      vecd[0] <= '{x: vec_in.vec_x, y: vec_in.vec_y, z: vec_in.vec_z};
      for (int i = 1; i < VD; i++) begin
        vecd[i] <= vecd[i-1];
      end
    end
  end

  // half-angle sine and cosine per axis
  eqvr_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_cordic_x (
    .clk(clk), .en(en), .angle(vec_in.angle_x), .sin_val(sx), .cos_val(cx));
  eqvr_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_cordic_y (
    .clk(clk), .en(en), .angle(vec_in.angle_y), .sin_val(sy), .cos_val(cy));
  eqvr_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_cordic_z (
    .clk(clk), .en(en), .angle(vec_in.angle_z), .sin_val(sz), .cos_val(cz));

  // qy*qx products (zero terms dropped)
  always_ff @(posedge clk) begin
    if (en) begin
      p_cysx <= PW'(cy) * PW'(sx);
      p_sycx <= PW'(sy) * PW'(cx);
      p_sysx <= PW'(sy) * PW'(sx);
      p_cycx <= PW'(cy) * PW'(cx);
      sz1 <= sz;
      cz1 <= cz;
    end
  end

  // round t = qy*qx
  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= eqvr_pkg::rnd30(RW'(p_cysx));
      t1 <= eqvr_pkg::rnd30(RW'(p_sycx));
      t2 <= eqvr_pkg::rnd30(-RW'(p_sysx));
      t3 <= eqvr_pkg::rnd30(RW'(p_cycx));
      sz2 <= sz1;
      cz2 <= cz1;
    end
  end

  // t*qz products
  always_ff @(posedge clk) begin
    if (en) begin
      pa0 <= PW'(t0) * PW'(cz2);
      pa1 <= PW'(t1) * PW'(sz2);
      pb0 <= PW'(t0) * PW'(sz2);
      pb1 <= PW'(t1) * PW'(cz2);
      pc0 <= PW'(t3) * PW'(sz2);
      pc1 <= PW'(t2) * PW'(cz2);
      pd0 <= PW'(t3) * PW'(cz2);
      pd1 <= PW'(t2) * PW'(sz2);
    end
  end

  // round q
  always_ff @(posedge clk) begin
    if (en) begin
      qx <= eqvr_pkg::rnd30(RW'(pa0) + RW'(pa1));
      qy <= eqvr_pkg::rnd30(RW'(pb1) - RW'(pb0));
      qz <= eqvr_pkg::rnd30(RW'(pc0) + RW'(pc1));
      qw <= eqvr_pkg::rnd30(RW'(pd0) - RW'(pd1));
    end
  end

  // quaternion component products
  always_ff @(posedge clk) begin
    if (en) begin
      ww <= PW'(qw) * PW'(qw);
      xx <= PW'(qx) * PW'(qx);
      yy <= PW'(qy) * PW'(qy);
      zz <= PW'(qz) * PW'(qz);
      xy <= PW'(qx) * PW'(qy);
      wz <= PW'(qw) * PW'(qz);
      xz <= PW'(qx) * PW'(qz);
      wy <= PW'(qw) * PW'(qy);
      yz <= PW'(qy) * PW'(qz);
      wx <= PW'(qw) * PW'(qx);
    end
  end

  // rotation matrix, Q29
  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= eqvr_pkg::rnd31(RW'(ww) + RW'(xx) - RW'(yy) - RW'(zz));
      m[1] <= eqvr_pkg::rnd30(RW'(xy) - RW'(wz));
      m[2] <= eqvr_pkg::rnd30(RW'(xz) + RW'(wy));
      m[3] <= eqvr_pkg::rnd30(RW'(xy) + RW'(wz));
      m[4] <= eqvr_pkg::rnd31(RW'(ww) - RW'(xx) + RW'(yy) - RW'(zz));
      m[5] <= eqvr_pkg::rnd30(RW'(yz) - RW'(wx));
      m[6] <= eqvr_pkg::rnd30(RW'(xz) - RW'(wy));
      m[7] <= eqvr_pkg::rnd30(RW'(yz) + RW'(wx));
      m[8] <= eqvr_pkg::rnd31(RW'(ww) - RW'(xx) - RW'(yy) + RW'(zz));
    end
  end

  assign vv[0] = vecd[VD-1].x;
  assign vv[1] = vecd[VD-1].y;
  assign vv[2] = vecd[VD-1].z;

  // matrix times vector products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        mv[i] <= MVW'(m[i]) * MVW'(vv[i % 3]);
      end
    end
  end

  // row sums, rounding and clamp
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = (RW'(mv[3*r]) + RW'(mv[3*r+1]) + RW'(mv[3*r+2]) + (RW'(1) <<< 28)) >>> 29;
      if (acc[r] > RW'(32'sh7fffffff)) begin
        clip[r] = 32'sh7fffffff;
        sat_row[r] = 1'b1;
      end else if (acc[r] < -(RW'(1) <<< 31)) begin
        clip[r] = 32'sh80000000;
        sat_row[r] = 1'b1;
      end else begin
        clip[r] = acc[r][VW-1:0];
        sat_row[r] = 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        res[r] <= clip[r];
      end
      vec_out.saturated <= |sat_row;
    end
  end

  assign vec_out.valid = vld[LAT-1];
  assign vec_out.out_x = res[0];
  assign vec_out.out_y = res[1];
  assign vec_out.out_z = res[2];

endmodule
